/* rtl/lrcr_pkg.sv */
// Shared types and constants for the link rate change reporter.
`default_nettype none
package lrcr_pkg;
  localparam int TimeW = 64;
  localparam int ByteW = 64;
  localparam int PktW  = 32;
  localparam int RateW = 48;
  localparam logic [RateW-1:0] RateMax = {RateW{1'b1}};
  localparam int FracBits = 19;
  localparam int QuoLimitBit = 29;

  typedef enum logic [1:0] {
    CFG_LOSS  = 2'd0,
    CFG_RMIN  = 2'd1,
    CFG_RATIO = 2'd2,
    CFG_TIME  = 2'd3
  } cfg_index_t;

  // which rate the divider works on
  typedef enum logic [1:0] {
    DIV_RC_UP   = 2'd0,
    DIV_RC_DOWN = 2'd1,
    DIV_RN_UP   = 2'd2,
    DIV_RN_DOWN = 2'd3
  } div_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DECIDE,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     read;
    logic     div_start;
    div_sel_t div_sel;
    logic     decide;
    logic     write;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic in_range;
  } stat_t;
endpackage
`default_nettype wire

/* rtl/link_rate_change_reporter_unit.sv */
// Top level of the link rate change reporter.
//
// Input channel: in_valid/in_stall with one counter sample per word
// (link_index, time_us and cumulative byte/packet counters).
// Output channel: out_valid/out_stall, one result word per sample: the
// report flag, link and, when reported, the running interval's deltas and
// rates (bits per microsecond, Q.16, saturated); otherwise zeros.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// loss threshold, 1 minimum rate change, 2 ratio (Q8.8), 3 time limit.
// Write only while idle; cfg_ready is high only while idle with no output word pending.
// From input accept to out_valid a sample passes the table read, four
// successive divisions in the single shared bit-serial divider, the
// decision and the output state. Out-of-range links skip the divisions.
// One sample is in work at a time; the next is accepted as soon as the
// result is handed to the output register, which may still be stalled.
// Reset clears configuration to defaults and all snapshot entries to zero
// through per-entry valid bits; no clearing pass is needed.
// A stalled output holds its word; the block then waits in its output
// state before writing back the sample.
`default_nettype none
module link_rate_change_reporter_unit #(
  parameter int LINKS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  link_index,
  input  wire logic [63:0] time_us,
  input  wire logic [63:0] total_sent,
  input  wire logic [63:0] total_received,
  input  wire logic [31:0] total_frames,
  input  wire logic [31:0] total_lost,
  input  wire logic [31:0] total_misordered,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             report,
  output logic [3:0]       link_out,
  output logic [63:0]      interval_age_us,
  output logic [63:0]      sent_delta,
  output logic [63:0]      received_delta,
  output logic [31:0]      frames_delta,
  output logic [31:0]      lost_delta,
  output logic [31:0]      misordered_delta,
  output logic [47:0]      uplink_rate,
  output logic [47:0]      downlink_rate,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import lrcr_pkg::*;
  cmd_t cmd;
  stat_t stat;
  logic busy;

  // accept configuration whenever the controller is idle and no output word is pending
  assign cfg_ready = !busy;

  lrcr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat),
    .busy(busy)
  );

  lrcr_datapath #(.LINKS(LINKS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .link_index(link_index), .time_us(time_us), .total_sent(total_sent),
    .total_received(total_received), .total_frames(total_frames),
    .total_lost(total_lost), .total_misordered(total_misordered),
    .report(report), .link_out(link_out), .interval_age_us(interval_age_us),
    .sent_delta(sent_delta), .received_delta(received_delta),
    .frames_delta(frames_delta), .lost_delta(lost_delta),
    .misordered_delta(misordered_delta), .uplink_rate(uplink_rate),
    .downlink_rate(downlink_rate)
  );
endmodule
`default_nettype wire

/* rtl/lrcr_divider.sv */
// Iterative rate divider: floor(bytes * 2^19 / age), saturated, one bit per cycle.
`default_nettype none
module lrcr_divider (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [lrcr_pkg::ByteW-1:0] bytes,
  input  wire logic [lrcr_pkg::TimeW-1:0] age,
  output logic                          done,
  output logic [lrcr_pkg::RateW-1:0]    rate
);
  import lrcr_pkg::*;
  localparam int Steps = ByteW + FracBits;
  localparam int CntW = $clog2(Steps + 1);

  // long division of bytes << 19 by age; 65-bit remainder handles carry-out
  logic [TimeW:0] rem;
  logic [Steps-1:0] dividend;
  logic [Steps-1:0] quo;
  logic [TimeW-1:0] divisor;
  logic [CntW-1:0] cnt;
  logic busy;
  logic [TimeW:0] shifted;
  logic take;

  assign shifted = {rem[TimeW-1:0], dividend[Steps-1]};
  assign take = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(Steps);
        rem <= '0;
        dividend <= {bytes, {FracBits{1'b0}}};
        divisor <= age;
        quo <= '0;
      end else if (busy) begin
        rem <= take ? shifted - {1'b0, divisor} : shifted;
        dividend <= {dividend[Steps-2:0], 1'b0};
        quo <= {quo[Steps-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // zero age gives zero; integer part at or above 2^29 saturates
  always_comb begin
    if (divisor == '0) rate = '0;
    else if (|quo[Steps-1:QuoLimitBit+FracBits]) rate = RateMax;
    else rate = quo[RateW-1:0];
  end
endmodule
`default_nettype wire

/* rtl/lrcr_datapath.sv */
// Datapath: snapshot tables, interval deltas, rate divider and report test.
`default_nettype none
module lrcr_datapath #(
  parameter int LINKS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lrcr_pkg::cmd_t      cmd,
  output lrcr_pkg::stat_t          stat,
  input  wire logic                cfg_valid,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [63:0]         cfg_data,
  input  wire logic [3:0]          link_index,
  input  wire logic [63:0]         time_us,
  input  wire logic [63:0]         total_sent,
  input  wire logic [63:0]         total_received,
  input  wire logic [31:0]         total_frames,
  input  wire logic [31:0]         total_lost,
  input  wire logic [31:0]         total_misordered,
  output logic                     report,
  output logic [3:0]               link_out,
  output logic [63:0]              interval_age_us,
  output logic [63:0]              sent_delta,
  output logic [63:0]              received_delta,
  output logic [31:0]              frames_delta,
  output logic [31:0]              lost_delta,
  output logic [31:0]              misordered_delta,
  output logic [47:0]              uplink_rate,
  output logic [47:0]              downlink_rate
);
  import lrcr_pkg::*;
  localparam int AW = (LINKS > 1) ? $clog2(LINKS) : 1;
  localparam int VW = (LINKS > 1) ? LINKS : 2;

  typedef struct packed {
    logic [TimeW-1:0] t;
    logic [ByteW-1:0] s;
    logic [ByteW-1:0] r;
    logic [PktW-1:0]  f;
    logic [PktW-1:0]  l;
    logic [PktW-1:0]  m;
  } snap_t;

  logic [31:0] loss_thr;
  logic [RateW-1:0] rmin;
  logic [15:0] ratio;
  logic [31:0] time_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_thr <= 32'd10;
      rmin <= 48'd65536;
      ratio <= 16'd64;
      time_thr <= 32'd5000000;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_LOSS:  loss_thr <= cfg_data[31:0];
        CFG_RMIN:  rmin <= cfg_data[RateW-1:0];
        CFG_RATIO: ratio <= cfg_data[15:0];
        CFG_TIME:  time_thr <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // captured sample
  logic [3:0] lk;
  snap_t cur;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lk <= link_index;
      cur <= {time_us, total_sent, total_received, total_frames, total_lost,
              total_misordered};
    end
  end
  assign stat.in_range = {5'd0, lk} < 9'(LINKS);

  // snapshot memories, read data registered; valid bits give reset zero
  snap_t rec_mem [LINKS];
  snap_t run_mem [LINKS];
  logic [VW-1:0] rec_v, run_v;
  snap_t rec_q, run_q, rec, run;
  logic rec_qv, run_qv;
  logic rep;
  logic [AW-1:0] addr;
  assign addr = AW'(lk);

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rec_q <= rec_mem[addr];
      run_q <= run_mem[addr];
    end
    if (cmd.write) begin
      rec_mem[addr] <= cur;
      if (rep) run_mem[addr] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_v <= '0;
      run_v <= '0;
    end else if (cmd.write) begin
      rec_v[addr] <= 1'b1;
      if (rep) run_v[addr] <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rec_qv <= rec_v[addr];
      run_qv <= run_v[addr];
    end
  end
  assign rec = rec_qv ? rec_q : '0;
  assign run = run_qv ? run_q : '0;

  // interval deltas
  logic [TimeW-1:0] rc_age, rn_age;
  logic [ByteW-1:0] rc_s, rc_r, rn_s, rn_r;
  logic [PktW-1:0] rn_f, rn_l, rn_m;
  assign rc_age = cur.t - rec.t;
  assign rc_s = cur.s - rec.s;
  assign rc_r = cur.r - rec.r;
  assign rn_age = rec.t - run.t;
  assign rn_s = rec.s - run.s;
  assign rn_r = rec.r - run.r;
  assign rn_f = rec.f - run.f;
  assign rn_l = rec.l - run.l;
  assign rn_m = rec.m - run.m;

  // shared divider
  logic [ByteW-1:0] dv_bytes;
  logic [TimeW-1:0] dv_age;
  logic [RateW-1:0] dv_rate;
  div_sel_t sel_q;
  always_comb begin
    unique case (cmd.div_sel)
      DIV_RC_UP:   begin dv_bytes = rc_s; dv_age = rc_age; end
      DIV_RC_DOWN: begin dv_bytes = rc_r; dv_age = rc_age; end
      DIV_RN_UP:   begin dv_bytes = rn_s; dv_age = rn_age; end
      DIV_RN_DOWN: begin dv_bytes = rn_r; dv_age = rn_age; end
      default:     begin dv_bytes = rn_r; dv_age = rn_age; end
    endcase
  end

  lrcr_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .bytes(dv_bytes), .age(dv_age),
    .done(stat.div_done), .rate(dv_rate)
  );

  logic [RateW-1:0] rc_up, rc_dn, rn_up, rn_dn;
  always_ff @(posedge clk) begin
    if (cmd.div_start) sel_q <= cmd.div_sel;
    if (stat.div_done) begin
      unique case (sel_q)
        DIV_RC_UP:   rc_up <= dv_rate;
        DIV_RC_DOWN: rc_dn <= dv_rate;
        DIV_RN_UP:   rn_up <= dv_rate;
        DIV_RN_DOWN: rn_dn <= dv_rate;
        default: ;
      endcase
    end
  end

  // rate change test, one register after each product
  logic [RateW-1:0] d_up, d_dn;
  assign d_up = rc_up >= rn_up ? rc_up - rn_up : rn_up - rc_up;
  assign d_dn = rc_dn >= rn_dn ? rc_dn - rn_dn : rn_dn - rc_dn;
  logic [RateW+15:0] p_up, p_dn;
  logic [RateW+7:0] ds_up, ds_dn;
  logic min_up, min_dn, simple;
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      p_up <= {16'd0, rn_up} * {{RateW{1'b0}}, ratio};
      p_dn <= {16'd0, rn_dn} * {{RateW{1'b0}}, ratio};
      ds_up <= {d_up, 8'd0};
      ds_dn <= {d_dn, 8'd0};
      min_up <= d_up >= rmin;
      min_dn <= d_dn >= rmin;
      simple <= rn_l >= loss_thr || rn_m >= loss_thr ||
                rn_age >= {32'd0, time_thr};
    end
  end
  assign rep = stat.in_range && (simple ||
               (min_up && {8'd0, ds_up} >= p_up) ||
               (min_dn && {8'd0, ds_dn} >= p_dn));

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      link_out <= lk;
      report <= rep;
      interval_age_us <= rep ? rn_age : '0;
      sent_delta <= rep ? rn_s : '0;
      received_delta <= rep ? rn_r : '0;
      frames_delta <= rep ? rn_f : '0;
      lost_delta <= rep ? rn_l : '0;
      misordered_delta <= rep ? rn_m : '0;
      uplink_rate <= rep ? rn_up : '0;
      downlink_rate <= rep ? rn_dn : '0;
    end
  end
endmodule
`default_nettype wire

/* rtl/lrcr_ctrl.sv */
// Controller: sequences table read, four divisions, decision, write-back and output.
`default_nettype none
module lrcr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lrcr_pkg::cmd_t      cmd,
  input  wire lrcr_pkg::stat_t stat,
  output logic                busy
);
  import lrcr_pkg::*;
  state_t state, state_next;
  div_sel_t sel, sel_next;
  logic ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel <= DIV_RC_UP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sel <= sel_next;
      out_valid <= ov_next;
    end
  end

  assign in_stall = state != ST_IDLE;
  assign busy = state != ST_IDLE || out_valid;

  always_comb begin
    state_next = state;
    sel_next = sel;
    ov_next = out_valid && out_stall;
    cmd = '0;
    cmd.div_sel = sel;
    unique case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: begin
        cmd.read = 1'b1;
        sel_next = DIV_RC_UP;
        state_next = stat.in_range ? ST_DIV_START : ST_OUT;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          if (sel == DIV_RN_DOWN) begin
            state_next = ST_DECIDE;
          end else begin
            sel_next = div_sel_t'(sel + 2'd1);
            state_next = ST_DIV_START;
          end
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!(out_valid && out_stall)) begin
          cmd.out_load = 1'b1;
          cmd.write = stat.in_range;
          ov_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  ap_div_only_waiting: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> state == ST_DIV_WAIT) else $error("divider done out of sequence");
  ap_write_with_out: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> cmd.out_load) else $error("table write without output");
  ap_out_after: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid) else $error("output word lost");
endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for the link rate change reporter: directed table plus random samples.
module tb;
  import lrcr_pkg::*;

  // Clock, reset and block ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  link_index = '0;
  logic [63:0] time_us = '0;
  logic [63:0] total_sent = '0;
  logic [63:0] total_received = '0;
  logic [31:0] total_frames = '0;
  logic [31:0] total_lost = '0;
  logic [31:0] total_misordered = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic        report;
  logic [3:0]  link_out;
  logic [63:0] interval_age_us, sent_delta, received_delta;
  logic [31:0] frames_delta, lost_delta, misordered_delta;
  logic [47:0] uplink_rate, downlink_rate;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_LOSS;
  logic [63:0] cfg_data = '0;

  localparam int NumLinks = 16;
  // Worst legal stretch without any accepted word is the long hold-off plus
  // one sample's latency; allow a wide margin on top.
  localparam int HoldCycles = 2000;
  localparam int DrainCycles = 400;
  localparam int WatchdogLimit = 20000;

  always #4 clk = ~clk;

  link_rate_change_reporter_unit #(.LINKS(NumLinks)) u_dut (.*);

  typedef struct {
    logic [3:0]  link;
    logic [63:0] t;
    logic [63:0] sent;
    logic [63:0] recvd;
    logic [31:0] frames;
    logic [31:0] lost;
    logic [31:0] misord;
  } sample_t;

  typedef struct {
    logic        rep;
    logic [3:0]  link;
    logic [63:0] age;
    logic [63:0] sent;
    logic [63:0] recvd;
    logic [31:0] frames;
    logic [31:0] lost;
    logic [31:0] misord;
    logic [47:0] up;
    logic [47:0] down;
  } interval_report_t;

  // Predictor copy of the configuration
  logic [31:0] loss_limit;
  logic [47:0] min_rate_step;
  logic [15:0] rel_step_q8;
  logic [31:0] age_limit;

  // Predictor copy of the per-link snapshots: index 0 recent, 1 running
  logic [63:0] snap_time  [2][NumLinks];
  logic [63:0] snap_sent  [2][NumLinks];
  logic [63:0] snap_recvd [2][NumLinks];
  logic [31:0] snap_frames[2][NumLinks];
  logic [31:0] snap_lost  [2][NumLinks];
  logic [31:0] snap_misord[2][NumLinks];

  interval_report_t pending_reports[$];
  int mismatch_count = 0;

  // Word the sender drives now, and whether its result is typed in
  logic             drv_typed = 1'b0;
  interval_report_t drv_typed_result;

  // floor(bytes * 2^19 / age), saturated; zero age gives zero
  function automatic logic [47:0] bits_per_us(logic [63:0] bytes, logic [63:0] age);
    logic [63:0] q, r;
    logic [18:0] frac;
    logic carry;
    if (age == 64'd0) return '0;
    q = bytes / age;
    r = bytes % age;
    if (q >= (64'd1 << QuoLimitBit)) return RateMax;
    frac = '0;
    for (int i = 0; i < FracBits; i++) begin
      carry = r[63];
      r = {r[62:0], 1'b0};
      frac = {frac[17:0], 1'b0};
      if (carry || r >= age) begin
        r = r - age;
        frac[0] = 1'b1;
      end
    end
    return {q[28:0], frac};
  endfunction

  function automatic logic rate_moved(logic [47:0] recent_rate, logic [47:0] running_rate);
    logic [47:0] d;
    logic [63:0] lhs, rhs;
    d = (recent_rate >= running_rate) ? recent_rate - running_rate
                                      : running_rate - recent_rate;
    lhs = {16'd0, d} << 8;
    rhs = 64'(rel_step_q8) * 64'(running_rate);
    return (d >= min_rate_step) && (lhs >= rhs);
  endfunction

  // Advance the snapshot copy by one sample and return the expected word
  function automatic interval_report_t predict_interval(sample_t s);
    interval_report_t res;
    logic [63:0] rc_age, rn_age, rn_sent, rn_recvd;
    logic [31:0] rn_frames, rn_lost, rn_misord;
    logic [47:0] rc_up, rc_down, rn_up, rn_down;
    int k;
    k = s.link;
    res = '{rep: 1'b0, link: s.link, default: '0};
    rc_age   = s.t - snap_time[0][k];
    rc_up    = bits_per_us(s.sent - snap_sent[0][k], rc_age);
    rc_down  = bits_per_us(s.recvd - snap_recvd[0][k], rc_age);
    rn_age    = snap_time[0][k] - snap_time[1][k];
    rn_sent   = snap_sent[0][k] - snap_sent[1][k];
    rn_recvd  = snap_recvd[0][k] - snap_recvd[1][k];
    rn_frames = snap_frames[0][k] - snap_frames[1][k];
    rn_lost   = snap_lost[0][k] - snap_lost[1][k];
    rn_misord = snap_misord[0][k] - snap_misord[1][k];
    rn_up   = bits_per_us(rn_sent, rn_age);
    rn_down = bits_per_us(rn_recvd, rn_age);
    if (rn_lost >= loss_limit || rn_misord >= loss_limit ||
        rate_moved(rc_down, rn_down) || rate_moved(rc_up, rn_up) ||
        rn_age >= 64'(age_limit)) begin
      res = '{rep: 1'b1, link: s.link, age: rn_age, sent: rn_sent, recvd: rn_recvd,
              frames: rn_frames, lost: rn_lost, misord: rn_misord, up: rn_up,
              down: rn_down};
      snap_time[1][k]   = snap_time[0][k];
      snap_sent[1][k]   = snap_sent[0][k];
      snap_recvd[1][k]  = snap_recvd[0][k];
      snap_frames[1][k] = snap_frames[0][k];
      snap_lost[1][k]   = snap_lost[0][k];
      snap_misord[1][k] = snap_misord[0][k];
    end
    snap_time[0][k]   = s.t;
    snap_sent[0][k]   = s.sent;
    snap_recvd[0][k]  = s.recvd;
    snap_frames[0][k] = s.frames;
    snap_lost[0][k]   = s.lost;
    snap_misord[0][k] = s.misord;
    return res;
  endfunction

  initial begin
    loss_limit = 32'd10;
    min_rate_step = 48'd65536;
    rel_step_q8 = 16'd64;
    age_limit = 32'd5000000;
    for (int p = 0; p < 2; p++) begin
      for (int l = 0; l < NumLinks; l++) begin
        snap_time[p][l] = '0;
        snap_sent[p][l] = '0;
        snap_recvd[p][l] = '0;
        snap_frames[p][l] = '0;
        snap_lost[p][l] = '0;
        snap_misord[p][l] = '0;
      end
    end
  end

  // Accepted sample: predict its word and queue it. Accepted register write:
  // mirror it. Both sampled on the rising edge, before the block updates.
  always @(posedge clk) begin
    interval_report_t res;
    if (!rst && in_valid && !in_stall) begin
      res = predict_interval('{link: link_index, t: time_us, sent: total_sent,
                               recvd: total_received, frames: total_frames,
                               lost: total_lost, misord: total_misordered});
      pending_reports.push_back(drv_typed ? drv_typed_result : res);
    end
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOSS:  loss_limit = cfg_data[31:0];
        CFG_RMIN:  min_rate_step = cfg_data[47:0];
        CFG_RATIO: rel_step_q8 = cfg_data[15:0];
        CFG_TIME:  age_limit = cfg_data[31:0];
        default: ;
      endcase
    end
  end

  task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("tb: mismatch in %s: got %h, expected %h", field, got, want);
  endtask

  // Compare every accepted result word with the oldest expectation
  always @(posedge clk) begin
    interval_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        $display("tb: result word with nothing expected (link %0d)", link_out);
      end else begin
        want = pending_reports.pop_front();
        if (report !== want.rep) flag_mismatch("report", 64'(report), 64'(want.rep));
        if (link_out !== want.link) flag_mismatch("link_out", 64'(link_out), 64'(want.link));
        if (interval_age_us !== want.age) flag_mismatch("interval_age_us", interval_age_us, want.age);
        if (sent_delta !== want.sent) flag_mismatch("sent_delta", sent_delta, want.sent);
        if (received_delta !== want.recvd)
          flag_mismatch("received_delta", received_delta, want.recvd);
        if (frames_delta !== want.frames)
          flag_mismatch("frames_delta", 64'(frames_delta), 64'(want.frames));
        if (lost_delta !== want.lost) flag_mismatch("lost_delta", 64'(lost_delta), 64'(want.lost));
        if (misordered_delta !== want.misord)
          flag_mismatch("misordered_delta", 64'(misordered_delta), 64'(want.misord));
        if (uplink_rate !== want.up) flag_mismatch("uplink_rate", 64'(uplink_rate), 64'(want.up));
        if (downlink_rate !== want.down)
          flag_mismatch("downlink_rate", 64'(downlink_rate), 64'(want.down));
      end
    end
  end

  // Receiver: stall on a pattern of its own, switching mode every segment.
  // A requested hold-off stalls without a break so the block backs up.
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   seg_left = 0;
  int   stall_mode = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HoldCycles;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        seg_left = $urandom_range(20, 400);
      end
      seg_left = seg_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 7) < 5);
      endcase
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: timeout, no word moved for %0d cycles", quiet_cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  // Sender: offer one word and hold it until accepted
  task automatic offer_sample(sample_t s, logic typed, interval_report_t typed_res);
    @(negedge clk);
    in_valid <= 1'b1;
    link_index <= s.link;
    time_us <= s.t;
    total_sent <= s.sent;
    total_received <= s.recvd;
    total_frames <= s.frames;
    total_lost <= s.lost;
    total_misordered <= s.misord;
    drv_typed <= typed;
    drv_typed_result <= typed_res;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid for a gap whose length is set by n
  task automatic sender_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(cfg_index_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait out every expected word (each write-back comes with its output), then a margin
  task automatic drain_block();
    sender_gap(1);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_thresholds(logic [31:0] loss, logic [47:0] rmin, logic [15:0] ratio,
                                logic [31:0] tlim);
    write_reg(CFG_LOSS, 64'(loss));
    write_reg(CFG_RMIN, 64'(rmin));
    write_reg(CFG_RATIO, 64'(ratio));
    write_reg(CFG_TIME, 64'(tlim));
  endtask

  // Random generator state: per link, the last counters and a traffic level
  logic [63:0] gen_time [NumLinks];
  logic [63:0] gen_sent [NumLinks];
  logic [63:0] gen_recvd[NumLinks];
  logic [31:0] gen_frames[NumLinks];
  logic [31:0] gen_lost [NumLinks];
  logic [31:0] gen_misord[NumLinks];
  int          gen_up_bpu[NumLinks];
  int          gen_down_bpu[NumLinks];

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly a plausible next sample of a link; now and then pure noise
  function automatic sample_t next_sample();
    sample_t s;
    int k;
    logic [63:0] dt;
    k = $urandom_range(0, NumLinks - 1);
    s.link = 4'(k);
    if ($urandom_range(0, 99) < 12) begin
      s = '{link: 4'(k), t: rand64(), sent: rand64(), recvd: rand64(), frames: $urandom,
            lost: $urandom, misord: $urandom};
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        gen_up_bpu[k] = $urandom_range(0, 5000);
        gen_down_bpu[k] = $urandom_range(0, 5000);
      end
      case ($urandom_range(0, 9))
        0: dt = 64'd0;
        1: dt = 64'($urandom_range(4000000, 7000000));
        default: dt = 64'($urandom_range(1, 1500000));
      endcase
      s.t = gen_time[k] + dt;
      s.sent = gen_sent[k] + dt * 64'(gen_up_bpu[k]) + 64'($urandom_range(0, 999));
      s.recvd = gen_recvd[k] + dt * 64'(gen_down_bpu[k]) + 64'($urandom_range(0, 999));
      s.frames = gen_frames[k] + $urandom_range(0, 5000);
      s.lost = gen_lost[k] + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0);
      s.misord = gen_misord[k] + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0);
    end
    gen_time[k] = s.t;
    gen_sent[k] = s.sent;
    gen_recvd[k] = s.recvd;
    gen_frames[k] = s.frames;
    gen_lost[k] = s.lost;
    gen_misord[k] = s.misord;
    return s;
  endfunction

  // Random phase: bursts of random length, random gaps, some calm stretches.
  // Optionally pause midway until every expected word is back.
  task automatic run_random(int n, logic pause_midway);
    int burst_left;
    interval_report_t none;
    none = '{default: '0};
    burst_left = 0;
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) begin
        sender_gap(1);
        while (pending_reports.size() != 0) @(posedge clk);
      end
      offer_sample(next_sample(), 1'b0, none);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 30));
      end else begin
        burst_left--;
      end
    end
  endtask

  // Directed table: link, time, sent, received, frames, lost, misordered,
  // and whether the result is typed in (then a quiet word, zero but for the link)
  typedef struct {
    sample_t s;
    logic    typed;
  } dir_row_t;
  dir_row_t dir_rows[$];

  task automatic add_row(logic [3:0] l, logic [63:0] t, logic [63:0] snt, logic [63:0] rcv,
                         logic [31:0] fr, logic [31:0] ls, logic [31:0] mo, logic typed);
    dir_rows.push_back('{s: '{link: l, t: t, sent: snt, recvd: rcv, frames: fr, lost: ls,
                              misord: mo}, typed: typed});
  endtask

  initial begin
    interval_report_t quiet;
    for (int l = 0; l < NumLinks; l++) begin
      gen_time[l] = '0;
      gen_sent[l] = '0;
      gen_recvd[l] = '0;
      gen_frames[l] = '0;
      gen_lost[l] = '0;
      gen_misord[l] = '0;
      gen_up_bpu[l] = $urandom_range(0, 3000);
      gen_down_bpu[l] = $urandom_range(0, 3000);
    end

    // Fresh link, zero sample: zero ages and rates, nothing to report
    add_row(4'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, 32'd0, 1'b1);
    // Steady link: recent rate against a zero running rate
    add_row(4'd0, 64'd1000, 64'd1000, 64'd2000, 32'd10, 32'd0, 32'd0, 1'b0);
    add_row(4'd0, 64'd2000, 64'd2000, 64'd4000, 32'd20, 32'd0, 32'd0, 1'b0);
    add_row(4'd0, 64'd3000, 64'd3000, 64'd6000, 32'd30, 32'd0, 32'd0, 1'b0);
    // Rate jumps up, then drops to zero
    add_row(4'd0, 64'd4000, 64'd900000, 64'd6000, 32'd40, 32'd0, 32'd0, 1'b0);
    add_row(4'd0, 64'd5000, 64'd900000, 64'd6000, 32'd50, 32'd0, 32'd0, 1'b0);
    add_row(4'd0, 64'd6000, 64'd900000, 64'd6000, 32'd60, 32'd0, 32'd0, 1'b0);
    // Lost and misordered counts crossing the threshold
    add_row(4'd1, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, 32'd0, 1'b1);
    add_row(4'd1, 64'd10, 64'd0, 64'd0, 32'd5, 32'd12, 32'd0, 1'b0);
    add_row(4'd1, 64'd20, 64'd0, 64'd0, 32'd5, 32'd12, 32'd0, 1'b0);
    add_row(4'd1, 64'd30, 64'd0, 64'd0, 32'd5, 32'd12, 32'hFFFFFFFF, 1'b0);
    add_row(4'd1, 64'd40, 64'd0, 64'd0, 32'd5, 32'd12, 32'hFFFFFFFF, 1'b0);
    // Old running interval ages out
    add_row(4'd2, 64'd6000000, 64'd0, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    add_row(4'd2, 64'd12000000, 64'd0, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    add_row(4'd2, 64'd12000001, 64'd0, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    // Field extremes on the top link, time going backwards
    add_row(4'd15, '1, '1, '1, '1, '1, '1, 1'b0);
    add_row(4'd15, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    add_row(4'd15, '1, '1, '1, '1, '1, '1, 1'b0);
    // Rate saturation: huge byte counts over one microsecond
    add_row(4'd3, 64'd1, '1, 64'h0000_4000_0000_0000, 32'd1, 32'd0, 32'd0, 1'b0);
    add_row(4'd3, 64'd2, 64'd5, 64'h0000_4000_0000_0001, 32'd2, 32'd0, 32'd0, 1'b0);
    add_row(4'd3, 64'd3, 64'd9, 64'h0000_8000_0000_0002, 32'd3, 32'd0, 32'd0, 1'b0);
    add_row(4'd3, 64'd4, 64'd9, 64'h0000_8000_0000_0002, 32'd3, 32'd0, 32'd0, 1'b0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with reset thresholds
    foreach (dir_rows[i]) begin
      quiet = '{rep: 1'b0, link: dir_rows[i].s.link, default: '0};
      offer_sample(dir_rows[i].s, dir_rows[i].typed, quiet);
      if (i % 4 == 3) sender_gap($urandom_range(1, 5));
    end
    drain_block();

    // Every threshold at zero: each sample reports
    set_thresholds('0, '0, '0, '0);
    run_random(60, 1'b0);
    drain_block();

    // Every threshold at its maximum: reports become rare
    set_thresholds('1, '1, '1, '1);
    run_random(150, 1'b0);
    drain_block();

    // Moderate thresholds under back-pressure: long output hold, then a pause
    set_thresholds($urandom_range(1, 20), 48'($urandom_range(1000, 300000)),
                   16'($urandom_range(0, 512)), $urandom_range(500000, 5000000));
    hold_req <= 1'b1;
    run_random(220, 1'b1);
    drain_block();

    // Another random setting for the rest
    set_thresholds($urandom_range(0, 8), 48'($urandom_range(0, 2000000)),
                   16'($urandom), $urandom_range(0, 8000000));
    run_random(300, 1'b0);
    drain_block();

    if (mismatch_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end
endmodule
